// File: rtl/script_token_scanner_core_defines.svh
// Assertion macros shared by the token scanner checker.
`ifndef SCRIPT_TOKEN_SCANNER_CORE_DEFINES_SVH
`define SCRIPT_TOKEN_SCANNER_CORE_DEFINES_SVH

// Immediate implication: prop must hold whenever cond holds.
`define STSC_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication: prop must hold in the cycle after cond holds.
`define STSC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: rtl/stsc_pkg.sv
// Shared types, codes and character constants of the token scanner.
package stsc_pkg;

	localparam int POS_BITS = 16;
	localparam int LEN_BITS = 16;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

	// token kinds
	localparam logic [3:0] K_EOF     = 4'd0;
	localparam logic [3:0] K_SEMI    = 4'd1;
	localparam logic [3:0] K_DOT     = 4'd2;
	localparam logic [3:0] K_EQUAL   = 4'd3;
	localparam logic [3:0] K_LPAREN  = 4'd4;
	localparam logic [3:0] K_RPAREN  = 4'd5;
	localparam logic [3:0] K_STRING  = 4'd6;
	localparam logic [3:0] K_IDENT   = 4'd7;
	localparam logic [3:0] K_ECHO    = 4'd8;
	localparam logic [3:0] K_UNKNOWN = 4'd9;

	// scan modes
	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_IDENT  = 2'd1;
	localparam logic [1:0] MODE_STRING = 2'd2;

	// keyword match progress
	localparam logic [2:0] KW_DONE = 3'd4;
	localparam logic [2:0] KW_FAIL = 3'd7;

	// characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	typedef struct packed {
		logic [3:0]          kind;
		logic [POS_BITS-1:0] start;
		logic [LEN_BITS-1:0] len;
	} stsc_tok_t;

	// one queue entry: every result caused by one accepted word
	typedef struct packed {
		logic      two;
		stsc_tok_t first;
		stsc_tok_t second;
	} stsc_entry_t;

	// letters of the echo keyword
	function automatic logic [7:0] kw_char(input logic [1:0] idx);
		logic [7:0] ch;
		case (idx)
			2'd0: ch = 8'h65;
			2'd1: ch = 8'h63;
			2'd2: ch = 8'h68;
			2'd3: ch = 8'h6F;
			default: ch = 8'h6F;
		endcase
		return ch;
	endfunction

endpackage

// File: rtl/stsc_front.sv
// Front end: classify each accepted byte, track scan state, build queue entries.
module stsc_front
	import stsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  logic [7:0]  src_byte,
	input  logic        end_mark,
	output logic        wr_en,
	output stsc_entry_t wr_entry
);

	logic [1:0]          mode_q, mode_n;
	logic [POS_BITS-1:0] pos_q, pos_n;
	logic [POS_BITS-1:0] org_q, org_n;
	logic [2:0]          kw_q, kw_n;
	logic                fin_q, fin_n;

	logic                at_end, is_alpha, is_digit, ident_ch, bump;
	logic [POS_BITS-1:0] pos_inc;
	logic [POS_BITS:0]   str_sum;
	logic [LEN_BITS-1:0] str_len;

	// idle-scan view of the byte
	logic                i_emit, i_bump, i_fin;
	logic [1:0]          i_mode;
	logic [POS_BITS-1:0] i_org;
	logic [2:0]          i_kw;
	stsc_tok_t           i_tok;

	always_comb begin
		at_end   = end_mark | (src_byte == CH_NUL);
		is_alpha = ((src_byte >= 8'h61) && (src_byte <= 8'h7A)) ||
		           ((src_byte >= 8'h41) && (src_byte <= 8'h5A));
		is_digit = (src_byte >= 8'h30) && (src_byte <= 8'h39);
		ident_ch = is_alpha | is_digit | (src_byte == CH_UNDER);
		pos_inc  = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;
		str_sum  = {1'b0, pos_q} + {{POS_BITS{1'b0}}, 1'b1} - {1'b0, org_q};
		str_len  = str_sum[POS_BITS] ? LEN_MAX : str_sum[LEN_BITS-1:0];
	end

	always_comb begin
		i_emit      = 1'b0;
		i_bump      = 1'b1;
		i_fin       = 1'b0;
		i_mode      = MODE_IDLE;
		i_org       = org_q;
		i_kw        = 3'd0;
		i_tok.kind  = K_UNKNOWN;
		i_tok.start = pos_q;
		i_tok.len   = LEN_BITS'(1);
		if (at_end) begin
			i_emit     = 1'b1;
			i_bump     = 1'b0;
			i_fin      = 1'b1;
			i_tok.kind = K_EOF;
			i_tok.len  = '0;
		end else begin
			case (src_byte)
				CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
					i_emit = 1'b0;
				end
				CH_SEMI: begin
					i_emit     = 1'b1;
					i_tok.kind = K_SEMI;
				end
				CH_DOT: begin
					i_emit     = 1'b1;
					i_tok.kind = K_DOT;
				end
				CH_EQUAL: begin
					i_emit     = 1'b1;
					i_tok.kind = K_EQUAL;
				end
				CH_LPAREN: begin
					i_emit     = 1'b1;
					i_tok.kind = K_LPAREN;
				end
				CH_RPAREN: begin
					i_emit     = 1'b1;
					i_tok.kind = K_RPAREN;
				end
				CH_QUOTE: begin
					i_mode = MODE_STRING;
					i_org  = pos_q;
				end
				default: begin
					if ((src_byte == CH_DOLLAR) || is_alpha) begin
						i_mode = MODE_IDENT;
						i_org  = pos_q;
						i_kw   = (src_byte == kw_char(2'd0)) ? 3'd1 : KW_FAIL;
					end else begin
						i_emit = 1'b1;
					end
				end
			endcase
		end
	end

	always_comb begin
		mode_n   = mode_q;
		org_n    = org_q;
		kw_n     = kw_q;
		fin_n    = fin_q;
		bump     = 1'b0;
		wr_en    = 1'b0;
		wr_entry = '0;
		if (!fin_q) begin
			case (mode_q)
				MODE_IDENT: begin
					if (!at_end && ident_ch) begin
						bump = 1'b1;
						if ((kw_q < KW_DONE) && (src_byte == kw_char(kw_q[1:0])))
							kw_n = kw_q + 3'd1;
						else
							kw_n = KW_FAIL;
					end else begin
						// close the identifier, then scan the byte from idle
						wr_en                = 1'b1;
						wr_entry.first.kind  = (kw_q == KW_DONE) ? K_ECHO : K_IDENT;
						wr_entry.first.start = org_q;
						wr_entry.first.len   = LEN_BITS'(pos_q - org_q);
						wr_entry.two         = i_emit;
						wr_entry.second      = i_tok;
						mode_n               = i_mode;
						org_n                = i_org;
						kw_n                 = i_kw;
						bump                 = i_bump;
						fin_n                = i_fin;
					end
				end
				MODE_STRING: begin
					if (at_end) begin
						wr_en                 = 1'b1;
						wr_entry.two          = 1'b1;
						wr_entry.first.kind   = K_UNKNOWN;
						wr_entry.first.start  = org_q;
						wr_entry.first.len    = '0;
						wr_entry.second.kind  = K_EOF;
						wr_entry.second.start = pos_q;
						wr_entry.second.len   = '0;
						mode_n                = MODE_IDLE;
						fin_n                 = 1'b1;
					end else if (src_byte == CH_QUOTE) begin
						wr_en                = 1'b1;
						wr_entry.first.kind  = K_STRING;
						wr_entry.first.start = org_q;
						wr_entry.first.len   = str_len;
						mode_n               = MODE_IDLE;
						bump                 = 1'b1;
					end else begin
						bump = 1'b1;
					end
				end
				default: begin
					wr_en          = i_emit;
					wr_entry.first = i_tok;
					mode_n         = i_mode;
					org_n          = i_org;
					kw_n           = i_kw;
					bump           = i_bump;
					fin_n          = i_fin;
				end
			endcase
		end
		wr_en = wr_en & acc;
		pos_n = bump ? pos_inc : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q  <= '0;
			org_q  <= '0;
			kw_q   <= '0;
			fin_q  <= 1'b0;
		end else if (acc) begin
			mode_q <= mode_n;
			pos_q  <= pos_n;
			org_q  <= org_n;
			kw_q   <= kw_n;
			fin_q  <= fin_n;
		end
	end

endmodule

// File: rtl/stsc_fifo.sv
// Short entry queue between the front and back ends.
module stsc_fifo
	import stsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  stsc_entry_t wr_entry,
	input  logic        rd_en,
	output stsc_entry_t rd_entry,
	output logic        nonempty,
	output logic        full
);

	stsc_entry_t           mem_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wptr_q, rptr_q;
	logic [Q_PTR_BITS:0]   cnt_q;

	assign rd_entry = mem_q[rptr_q];
	assign nonempty = (cnt_q != '0);
	assign full     = (cnt_q == (Q_PTR_BITS+1)'(Q_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en)
				wptr_q <= wptr_q + 1'b1;
			if (rd_en)
				rptr_q <= rptr_q + 1'b1;
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/stsc_back.sv
// Back end: split queue entries into single result words behind an output register.
module stsc_back
	import stsc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  stsc_entry_t         head,
	input  logic                head_valid,
	output logic                deq,
	input  logic                pop,
	output logic                empty,
	output logic [3:0]          tok_kind,
	output logic [POS_BITS-1:0] tok_start,
	output logic [LEN_BITS-1:0] tok_len,
	output logic                run_last
);

	logic      ov_q, half_q, last_q;
	stsc_tok_t tok_q;
	logic      load, take_first, is_last;
	stsc_tok_t nxt_tok;

	always_comb begin
		load       = head_valid && (!ov_q || pop);
		take_first = !head.two || !half_q;
		is_last    = !head.two || half_q;
		nxt_tok    = take_first ? head.first : head.second;
		deq        = load && is_last;
	end

	assign empty     = !ov_q;
	assign tok_kind  = tok_q.kind;
	assign tok_start = tok_q.start;
	assign tok_len   = tok_q.len;
	assign run_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			half_q <= 1'b0;
		end else begin
			if (load) begin
				ov_q   <= 1'b1;
				half_q <= !is_last;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= nxt_tok;
			last_q <= is_last;
		end
	end

endmodule

// File: rtl/script_token_scanner_core.sv
// Top level of the byte-serial script token scanner.
// The scanner takes one source byte per word on the push side and gives token
// records (kind, start position, length, run_last) on the pop side. A byte is
// taken in the cycle it is pushed whenever full is low, so the input runs at one
// byte per clock; the front end classifies the byte and updates the scan state
// in that same cycle. Each byte yields zero, one or two token words; these sit
// in a four-entry queue and the back end hands out one word per clock through
// an output register while pop keeps up, so a byte that closes an identifier
// and is itself a token (or an end of source) costs two pops. A pushed byte's
// first word is written into the queue, then loaded into the output register.
// run_last marks the final word that one input byte caused. A zero byte or
// end_mark closes the scan and emits EOF; every byte after that is taken and
// dropped until reset. Positions and lengths saturate at 65535.
module script_token_scanner_core
	import stsc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          src_byte,
	input  logic                end_mark,
	output logic                empty,
	input  logic                pop,
	output logic [3:0]          tok_kind,
	output logic [POS_BITS-1:0] tok_start,
	output logic [LEN_BITS-1:0] tok_len,
	output logic                run_last
);

	logic        acc;
	logic        wr_en;
	stsc_entry_t wr_entry;
	stsc_entry_t head;
	logic        head_valid;
	logic        deq;

	// accept a byte whenever the queue has room
	assign acc = push && !full;

	stsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.src_byte (src_byte),
		.end_mark (end_mark),
		.wr_en    (wr_en),
		.wr_entry (wr_entry)
	);

	stsc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_entry (wr_entry),
		.rd_en    (deq),
		.rd_entry (head),
		.nonempty (head_valid),
		.full     (full)
	);

	// drain entries one word per cycle while results are popped
	stsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.deq        (deq),
		.pop        (pop),
		.empty      (empty),
		.tok_kind   (tok_kind),
		.tok_start  (tok_start),
		.tok_len    (tok_len),
		.run_last   (run_last)
	);

endmodule

// File: rtl/stsc_checker.sv
// Port-level checker for the token scanner and its bind.
`include "script_token_scanner_core_defines.svh"

module stsc_checker
	import stsc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input logic [7:0]          src_byte,
	input logic                end_mark,
	input logic                empty,
	input logic                pop,
	input logic [3:0]          tok_kind,
	input logic [POS_BITS-1:0] tok_start,
	input logic [LEN_BITS-1:0] tok_len,
	input logic                run_last
);

	`STSC_ASSERT_NEXT(a_stall_holds, clk, arst_n, !empty && !pop, !empty, "result dropped while stalled")
	`STSC_ASSERT_NEXT(a_stall_stable, clk, arst_n, !empty && !pop, $stable({tok_kind, tok_start, tok_len, run_last}), "result changed while stalled")
	`STSC_ASSERT_NEXT(a_pair_follows, clk, arst_n, !empty && !run_last, !empty, "second word of a byte missing")
	`STSC_ASSERT_NOW(a_eof_shape, clk, arst_n, !empty && tok_kind == K_EOF, run_last && tok_len == '0, "bad EOF word")

endmodule

bind script_token_scanner_core stsc_checker u_chk (.*);
